// ----- design/slpt_pkg.sv -----
// Shared types and event codes for the secure lock presentation tracker.
package slpt_pkg;

  // Event kinds carried on req_type
  typedef enum logic [2:0] {
    REQ_LOCK      = 3'd0,
    REQ_UNLOCK    = 3'd1,
    REQ_DESTROY   = 3'd2,
    REQ_OUT_ADD   = 3'd3,
    REQ_OUT_REM   = 3'd4,
    REQ_PENDING   = 3'd5,
    REQ_FAILED    = 3'd6,
    REQ_PRESENTED = 3'd7
  } req_kind_e;

  // Width of the reported frame request mask
  localparam int unsigned MaskW = 8;
  // Width of the commit sequence number
  localparam int unsigned SeqW  = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the item on the input ports
    logic exec;  // apply the captured item to the slot table
  } cmd_t;

endpackage

// ----- design/slpt_ctrl.sv -----
// Controller: tracks whether a captured item waits to be applied.
module slpt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  output slpt_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  // Advance to execute whenever an item is captured
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:  state_q <= accept_i ? S_EXEC : S_IDLE;
        S_EXEC:  state_q <= accept_i ? S_EXEC : S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Drive commands
  assign cmd_o.load = accept_i;
  assign cmd_o.exec = (state_q == S_EXEC);

endmodule

// ----- design/slpt_datapath.sv -----
// Datapath: item capture, slot table, lock flags and result registers.
module slpt_datapath #(
  parameter int unsigned MAX_OUTPUTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slpt_pkg::cmd_t                cmd_i,
  input  logic [2:0]                    req_type_i,
  input  logic [2:0]                    output_slot_i,
  input  logic [slpt_pkg::SeqW-1:0]     commit_seq_i,
  input  logic                          present_ok_i,
  input  logic                          geometry_ok_i,
  output logic                          done_o,
  output logic                          send_locked_o,
  output logic                          lock_rejected_o,
  output logic                          secure_active_o,
  output logic                          locked_status_o,
  output logic [slpt_pkg::MaskW-1:0]    frame_request_mask_o
);

  localparam int unsigned IdxW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  // Captured item
  logic [2:0]                req_q;
  logic [2:0]                slot_q;
  logic [slpt_pkg::SeqW-1:0] seq_q;
  logic                      pres_ok_q;
  logic                      geom_ok_q;

  // Lock flags
  logic attached_q, attached_d;
  logic secure_q, secure_d;
  logic conf_q, conf_d;

  // Slot table
  logic [MAX_OUTPUTS-1:0]    valid_q, valid_d;
  logic [MAX_OUTPUTS-1:0]    pres_q, pres_d;
  logic [MAX_OUTPUTS-1:0]    pend_q, pend_d;
  logic [slpt_pkg::SeqW-1:0] slot_seq_q [MAX_OUTPUTS];
  logic                      seq_we;

  // Results
  logic                       done_q;
  logic                       sent_q, sent_d;
  logic                       rej_q, rej_d;
  logic [slpt_pkg::MaskW-1:0] mask_q, mask_d;

  // Slot decode
  logic [IdxW+2:0]           slot_ext;
  logic [IdxW-1:0]           idx;
  logic                      slot_in;
  logic [slpt_pkg::SeqW-1:0] seq_diff;
  logic [slpt_pkg::MaskW-1:0] valid_mask;
  logic                      all_pres;
  logic                      try_ok;

  assign slot_ext = {{IdxW{1'b0}}, slot_q};
  assign idx      = slot_ext[IdxW-1:0];
  assign slot_in  = (32'(slot_q) < 32'(MAX_OUTPUTS));
  assign seq_diff = seq_q - slot_seq_q[idx];

  // Report valid slots that fit in the mask
  always_comb begin
    valid_mask = '0;
    for (int i = 0; i < slpt_pkg::MaskW; i++) begin
      if (i < MAX_OUTPUTS) begin
        valid_mask[i] = valid_q[i];
      end
    end
  end

  // Apply the captured item to the flags and the slot table
  always_comb begin
    attached_d = attached_q;
    secure_d   = secure_q;
    conf_d     = conf_q;
    valid_d    = valid_q;
    pres_d     = pres_q;
    pend_d     = pend_q;
    seq_we     = 1'b0;
    rej_d      = 1'b0;
    mask_d     = '0;
    try_ok     = 1'b0;
    case (slpt_pkg::req_kind_e'(req_q))
      slpt_pkg::REQ_LOCK: begin
        if (attached_q) begin
          rej_d = 1'b1;
        end else begin
          attached_d = 1'b1;
          secure_d   = 1'b1;
          conf_d     = 1'b0;
          pres_d     = pres_q & ~valid_q;
          pend_d     = pend_q & ~valid_q;
          mask_d     = valid_mask;
          try_ok     = 1'b1;
        end
      end
      slpt_pkg::REQ_UNLOCK: begin
        if (attached_q && conf_q) begin
          secure_d = 1'b0;
          conf_d   = 1'b0;
        end
      end
      slpt_pkg::REQ_DESTROY: begin
        if (attached_q) begin
          attached_d = 1'b0;
          conf_d     = 1'b0;
          if (!conf_q) begin
            secure_d = 1'b0;
          end else begin
            // Locker lost after confirmation: stay secure, redraw everything
            pres_d = pres_q & ~valid_q;
            pend_d = pend_q & ~valid_q;
            mask_d = valid_mask;
          end
        end
      end
      slpt_pkg::REQ_OUT_ADD: begin
        if (slot_in && !valid_q[idx] && geom_ok_q) begin
          valid_d[idx] = 1'b1;
          pres_d[idx]  = !secure_q;
          pend_d[idx]  = 1'b0;
          if (secure_q) begin
            mask_d = slpt_pkg::MaskW'(1) << slot_q;
          end
        end
      end
      slpt_pkg::REQ_OUT_REM: begin
        if (slot_in && valid_q[idx]) begin
          valid_d[idx] = 1'b0;
          pres_d[idx]  = 1'b0;
          pend_d[idx]  = 1'b0;
          try_ok       = 1'b1;
        end
      end
      slpt_pkg::REQ_PENDING: begin
        if (secure_q && slot_in && valid_q[idx] && !pres_q[idx] && !pend_q[idx]) begin
          seq_we      = 1'b1;
          pend_d[idx] = 1'b1;
        end
      end
      slpt_pkg::REQ_FAILED: begin
        if (secure_q && slot_in && valid_q[idx] && pend_q[idx] &&
            (slot_seq_q[idx] == seq_q)) begin
          pend_d[idx] = 1'b0;
        end
      end
      slpt_pkg::REQ_PRESENTED: begin
        // Accept only a sequence that is not older, by wrap-around difference
        if (secure_q && pres_ok_q && slot_in && valid_q[idx] && !pres_q[idx] &&
            pend_q[idx] && !seq_diff[slpt_pkg::SeqW-1]) begin
          pres_d[idx] = 1'b1;
          pend_d[idx] = 1'b0;
          try_ok      = 1'b1;
        end
      end
      default: ;
    endcase

    // Confirm once every valid slot has presented while secure
    all_pres = &(~valid_d | pres_d);
    sent_d   = try_ok && attached_d && !conf_d && secure_d && all_pres;
    if (sent_d) begin
      conf_d = 1'b1;
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_type_i;
      slot_q    <= output_slot_i;
      seq_q     <= commit_seq_i;
      pres_ok_q <= present_ok_i;
      geom_ok_q <= geometry_ok_i;
    end
  end

  // Hold sequence numbers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && seq_we) begin
      slot_seq_q[idx] <= seq_q;
    end
  end

  // Update flags, table and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q <= 1'b0;
      secure_q   <= 1'b0;
      conf_q     <= 1'b0;
      valid_q    <= '0;
      pres_q     <= '0;
      pend_q     <= '0;
      done_q     <= 1'b0;
      sent_q     <= 1'b0;
      rej_q      <= 1'b0;
      mask_q     <= '0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        attached_q <= attached_d;
        secure_q   <= secure_d;
        conf_q     <= conf_d;
        valid_q    <= valid_d;
        pres_q     <= pres_d;
        pend_q     <= pend_d;
        sent_q     <= sent_d;
        rej_q      <= rej_d;
        mask_q     <= mask_d;
      end
    end
  end

  assign done_o               = done_q;
  assign send_locked_o        = sent_q;
  assign lock_rejected_o      = rej_q;
  assign secure_active_o      = secure_q;
  assign locked_status_o      = conf_q;
  assign frame_request_mask_o = mask_q;

endmodule

// ----- design/secure_lock_present_tracker.sv -----
// Top level of the secure lock presentation tracker.
// The block takes one item in every clock cycle: busy stays low and start may be held
// high back to back. An accepted item is captured into the input registers, applied to
// the slot table in the execute state, and its result is registered and shown with
// done_o high for a single cycle. The combinational update of the slot table (one
// 32-bit wrap-around compare and a reduction over MAX_OUTPUTS slots) sets this rate.
// Results cannot be held off; done_o marks the one cycle in which they are valid.
module secure_lock_present_tracker #(
  parameter int unsigned MAX_OUTPUTS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type_i,
  input  logic [2:0]                  output_slot_i,
  input  logic [slpt_pkg::SeqW-1:0]   commit_seq_i,
  input  logic                        present_ok_i,
  input  logic                        geometry_ok_i,
  output logic                        done_o,
  output logic                        send_locked_o,
  output logic                        lock_rejected_o,
  output logic                        secure_active_o,
  output logic                        locked_status_o,
  output logic [slpt_pkg::MaskW-1:0]  frame_request_mask_o
);

  slpt_pkg::cmd_t cmd;
  logic           accept;

  // Items are taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  slpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_o    (cmd)
  );

  slpt_datapath #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .req_type_i           (req_type_i),
    .output_slot_i        (output_slot_i),
    .commit_seq_i         (commit_seq_i),
    .present_ok_i         (present_ok_i),
    .geometry_ok_i        (geometry_ok_i),
    .done_o               (done_o),
    .send_locked_o        (send_locked_o),
    .lock_rejected_o      (lock_rejected_o),
    .secure_active_o      (secure_active_o),
    .locked_status_o      (locked_status_o),
    .frame_request_mask_o (frame_request_mask_o)
  );

  // A confirmation leaves the block locked and secure
  a_sent_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && send_locked_o |-> locked_status_o && secure_active_o)
    else $error("confirmation without locked secure state");

  // A refusal never coincides with a confirmation
  a_reject_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(lock_rejected_o && send_locked_o))
    else $error("lock refused and confirmed together");

  // Locked status implies secure mode
  a_locked_secure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_status_o |-> secure_active_o)
    else $error("locked status outside secure mode");

  // Every accepted item yields a done_o strobe once it has been captured and applied
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted item produced no result");

endmodule

// ----- dv/secure_lock_present_tracker_tb.sv -----
// Self-checking bench for the secure lock presentation tracker: queued item driver, result monitor.
module secure_lock_present_tracker_tb;

  localparam int SlotCount   = 8;
  localparam int ItemTarget  = 1700;
  localparam int IdleLimit   = 1000;

  // One event as presented on the input ports
  typedef struct {
    slpt_pkg::req_kind_e       kind;
    logic [2:0]                slot;
    logic [slpt_pkg::SeqW-1:0] seq;
    logic                      pres_ok;
    logic                      geom_ok;
    logic                      drain;  // wait for all results before presenting
  } lock_event_t;

  // One result as shown while done_o is high
  typedef struct packed {
    logic                       sent;
    logic                       rejected;
    logic                       secure;
    logic                       locked;
    logic [slpt_pkg::MaskW-1:0] frame_req;
  } lock_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [2:0]                 req_type_i = '0;
  logic [2:0]                 output_slot_i = '0;
  logic [slpt_pkg::SeqW-1:0]  commit_seq_i = '0;
  logic                       present_ok_i = 1'b0;
  logic                       geometry_ok_i = 1'b0;
  logic                       done_o;
  logic                       send_locked_o;
  logic                       lock_rejected_o;
  logic                       secure_active_o;
  logic                       locked_status_o;
  logic [slpt_pkg::MaskW-1:0] frame_request_mask_o;

  secure_lock_present_tracker #(
    .MAX_OUTPUTS(SlotCount)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .req_type_i          (req_type_i),
    .output_slot_i       (output_slot_i),
    .commit_seq_i        (commit_seq_i),
    .present_ok_i        (present_ok_i),
    .geometry_ok_i       (geometry_ok_i),
    .done_o              (done_o),
    .send_locked_o       (send_locked_o),
    .lock_rejected_o     (lock_rejected_o),
    .secure_active_o     (secure_active_o),
    .locked_status_o     (locked_status_o),
    .frame_request_mask_o(frame_request_mask_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the tracker state
  logic                      lk_attached = 1'b0;
  logic                      lk_secure = 1'b0;
  logic                      lk_confirmed = 1'b0;
  logic [SlotCount-1:0]      sl_valid = '0;
  logic [SlotCount-1:0]      sl_presented = '0;
  logic [SlotCount-1:0]      sl_pending = '0;
  logic [slpt_pkg::SeqW-1:0] sl_seq [SlotCount];

  lock_event_t  event_q [$];
  lock_result_t expected_results [$];
  lock_event_t  on_ports;
  lock_result_t got_result;
  lock_result_t want_result;
  int           mismatch_count = 0;
  int           gap_left = 0;
  int           burst_left = 1;
  int           idle_cycles = 0;
  logic [slpt_pkg::SeqW-1:0] gen_seq;

  // Confirm the lock once every valid slot has presented while secure
  function automatic logic try_confirm();
    if (lk_attached && !lk_confirmed && lk_secure && (&(~sl_valid | sl_presented))) begin
      lk_confirmed = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drop presentation on every valid slot and request fresh frames there
  function automatic logic [slpt_pkg::MaskW-1:0] restart_frames();
    sl_presented &= ~sl_valid;
    sl_pending   &= ~sl_valid;
    return slpt_pkg::MaskW'(sl_valid);
  endfunction

  // Apply one item to the shadow state and return its result
  function automatic lock_result_t apply_lock_event(lock_event_t ev);
    lock_result_t r;
    logic [slpt_pkg::SeqW-1:0] age;
    int s;
    logic conf_before;
    r = '0;
    s = int'(ev.slot);
    case (ev.kind)
      slpt_pkg::REQ_LOCK: begin
        if (lk_attached) begin
          r.rejected = 1'b1;
        end else begin
          lk_attached  = 1'b1;
          lk_secure    = 1'b1;
          lk_confirmed = 1'b0;
          r.frame_req  = restart_frames();
          r.sent       = try_confirm();
        end
      end
      slpt_pkg::REQ_UNLOCK: begin
        if (lk_attached && lk_confirmed) begin
          lk_secure    = 1'b0;
          lk_confirmed = 1'b0;
        end
      end
      slpt_pkg::REQ_DESTROY: begin
        if (lk_attached) begin
          conf_before  = lk_confirmed;
          lk_attached  = 1'b0;
          lk_confirmed = 1'b0;
          if (!conf_before) lk_secure = 1'b0;
          else r.frame_req = restart_frames();
        end
      end
      slpt_pkg::REQ_OUT_ADD: begin
        if (s < SlotCount && !sl_valid[s] && ev.geom_ok) begin
          sl_valid[s]     = 1'b1;
          sl_presented[s] = !lk_secure;
          sl_pending[s]   = 1'b0;
          if (lk_secure) r.frame_req[s] = 1'b1;
        end
      end
      slpt_pkg::REQ_OUT_REM: begin
        if (s < SlotCount && sl_valid[s]) begin
          sl_valid[s]     = 1'b0;
          sl_presented[s] = 1'b0;
          sl_pending[s]   = 1'b0;
          r.sent          = try_confirm();
        end
      end
      slpt_pkg::REQ_PENDING: begin
        if (lk_secure && s < SlotCount && sl_valid[s] && !sl_presented[s] &&
            !sl_pending[s]) begin
          sl_seq[s]     = ev.seq;
          sl_pending[s] = 1'b1;
        end
      end
      slpt_pkg::REQ_FAILED: begin
        if (lk_secure && s < SlotCount && sl_valid[s] && sl_pending[s] && sl_seq[s] == ev.seq)
          sl_pending[s] = 1'b0;
      end
      default: begin
        if (lk_secure && ev.pres_ok && s < SlotCount && sl_valid[s] && !sl_presented[s] &&
            sl_pending[s]) begin
          age = ev.seq - sl_seq[s];
          if (!age[slpt_pkg::SeqW-1]) begin
            sl_presented[s] = 1'b1;
            sl_pending[s]   = 1'b0;
            r.sent          = try_confirm();
          end
        end
      end
    endcase
    r.secure = lk_secure;
    r.locked = lk_confirmed;
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endtask

  // Append one item to the stimulus queue
  task automatic queue_event(slpt_pkg::req_kind_e k, int slot, logic [slpt_pkg::SeqW-1:0] seq,
                             logic pok, logic gok, logic drain = 1'b0);
    lock_event_t ev;
    ev.kind    = k;
    ev.slot    = slot[2:0];
    ev.seq     = seq;
    ev.pres_ok = pok;
    ev.geom_ok = gok;
    ev.drain   = drain;
    event_q.push_back(ev);
  endtask

  // Pick a commit number, often close to the wrap point
  function automatic logic [slpt_pkg::SeqW-1:0] pick_seq();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF - $urandom_range(0, 20);
      1:       return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  // Pick a gap between the stored and the presented number
  function automatic logic [slpt_pkg::SeqW-1:0] pick_delta();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2, 3:    return $urandom_range(1, 100);
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h8000_0000;
      6:       return 32'hFFFF_FFFF - $urandom_range(0, 50);
      default: return $urandom;
    endcase
  endfunction

  // Add a noise item with every field random
  task automatic queue_noise();
    queue_event(slpt_pkg::req_kind_e'($urandom_range(0, 7)), $urandom_range(0, 7), $urandom,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Build one lock session: outputs, lock, commits per slot, then mostly a release
  task automatic queue_session();
    logic [slpt_pkg::SeqW-1:0] delta;
    logic                      pok;
    int                        n;
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) queue_event(slpt_pkg::REQ_OUT_ADD, $urandom_range(0, 7), $urandom,
                             1'($urandom_range(0, 1)), $urandom_range(0, 5) != 0);
    end
    if ($urandom_range(0, 3) == 0)
      queue_event(slpt_pkg::REQ_OUT_REM, $urandom_range(0, 7), $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    queue_event(slpt_pkg::REQ_LOCK, $urandom_range(0, 7), $urandom, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 7) == 0)
      queue_event(slpt_pkg::REQ_LOCK, $urandom_range(0, 7), $urandom, 1'b1, 1'b1);
    for (int s = 0; s < SlotCount; s++) begin
      if ($urandom_range(0, 3) == 0) continue;
      if ($urandom_range(0, 9) == 0)
        queue_event($urandom_range(0, 1) ? slpt_pkg::REQ_OUT_ADD : slpt_pkg::REQ_OUT_REM,
                    $urandom_range(0, 7), $urandom, 1'b1, 1'b1);
      gen_seq = pick_seq();
      queue_event(slpt_pkg::REQ_PENDING, s, gen_seq, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) begin
        queue_event(slpt_pkg::REQ_FAILED, s, gen_seq, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        gen_seq = pick_seq();
        queue_event(slpt_pkg::REQ_PENDING, s, gen_seq, 1'b1, 1'b1);
      end
      delta = pick_delta();
      pok   = $urandom_range(0, 9) != 0;
      queue_event(slpt_pkg::REQ_PRESENTED, s, gen_seq + delta, pok, 1'($urandom_range(0, 1)));
      // Follow a refused presentation with a good one
      if (delta[slpt_pkg::SeqW-1] || !pok)
        queue_event(slpt_pkg::REQ_PRESENTED, s, gen_seq + $urandom_range(0, 3), 1'b1, 1'b1);
    end
    case ($urandom_range(0, 19))
      0, 1, 2:  ;
      3, 4, 5, 6, 7, 8, 9: begin
        queue_event(slpt_pkg::REQ_DESTROY, $urandom_range(0, 7), $urandom, 1'b1, 1'b1);
        if ($urandom_range(0, 1)) queue_event(slpt_pkg::REQ_LOCK, 0, $urandom, 1'b1, 1'b1);
      end
      default: queue_event(slpt_pkg::REQ_UNLOCK, $urandom_range(0, 7), $urandom, 1'b1, 1'b1);
    endcase
  endtask

  // Drive items from the queue in bursts and predict each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_results.push_back(apply_lock_event(on_ports));
      if (start && busy) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (event_q.size() > 0 &&
                   (!event_q[0].drain || (expected_results.size() == 0 && !start))) begin
        on_ports       = event_q.pop_front();
        req_type_i    <= on_ports.kind;
        output_slot_i <= on_ports.slot;
        commit_seq_i  <= on_ports.seq;
        present_ok_i  <= on_ports.pres_ok;
        geometry_ok_i <= on_ports.geom_ok;
        start         <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got_result = '{send_locked_o, lock_rejected_o, secure_active_o, locked_status_o,
                     frame_request_mask_o};
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding", '0, 32'(got_result));
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.sent !== want_result.sent)
          report_mismatch("send_locked", 32'(want_result.sent), 32'(got_result.sent));
        if (got_result.rejected !== want_result.rejected)
          report_mismatch("lock_rejected", 32'(want_result.rejected),
                          32'(got_result.rejected));
        if (got_result.secure !== want_result.secure)
          report_mismatch("secure_active", 32'(want_result.secure), 32'(got_result.secure));
        if (got_result.locked !== want_result.locked)
          report_mismatch("locked_status", 32'(want_result.locked), 32'(got_result.locked));
        if (got_result.frame_req !== want_result.frame_req)
          report_mismatch("frame_request_mask", 32'(want_result.frame_req),
                          32'(got_result.frame_req));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    foreach (sl_seq[i]) sl_seq[i] = '0;

    // Directed: release without lock, empty-table lock, refusal, unlock, early destroy
    queue_event(slpt_pkg::REQ_UNLOCK, 0, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_DESTROY, 0, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_LOCK, 0, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_LOCK, 7, 32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_event(slpt_pkg::REQ_UNLOCK, 0, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_DESTROY, 0, '0, 1'b0, 1'b0);
    // Outputs: zero size ignored, plain adds, commit outside secure mode ignored
    queue_event(slpt_pkg::REQ_OUT_ADD, 0, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_OUT_ADD, 0, '0, 1'b0, 1'b1);
    queue_event(slpt_pkg::REQ_OUT_ADD, 7, '0, 1'b0, 1'b1);
    queue_event(slpt_pkg::REQ_PENDING, 0, 32'h1234_5678, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_LOCK, 0, '0, 1'b0, 1'b0, 1'b1);
    // Commit, fail and present across the wrap point
    queue_event(slpt_pkg::REQ_PENDING, 0, 32'hFFFF_FFF0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_FAILED, 0, 32'h0000_0001, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_FAILED, 0, 32'hFFFF_FFF0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_PENDING, 0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_PRESENTED, 0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    queue_event(slpt_pkg::REQ_PRESENTED, 0, 32'h0000_0005, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_PRESENTED, 0, 32'h7FFF_FFFE, 1'b1, 1'b0);
    queue_event(slpt_pkg::REQ_OUT_ADD, 3, '0, 1'b0, 1'b1);
    queue_event(slpt_pkg::REQ_PENDING, 7, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_PRESENTED, 7, '0, 1'b1, 1'b1);
    // Removing the last unpresented slot confirms; then the locker goes away
    queue_event(slpt_pkg::REQ_OUT_REM, 3, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_DESTROY, 0, '0, 1'b0, 1'b0);
    queue_event(slpt_pkg::REQ_PRESENTED, 0, '0, 1'b1, 1'b1);
    queue_event(slpt_pkg::REQ_LOCK, 0, '0, 1'b0, 1'b0, 1'b1);

    // Random: mostly well-formed sessions, some noise
    while (event_q.size() < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) queue_noise();
      else queue_session();
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (event_q.size() != 0 || start || expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
